// ----- src/stack_calculator_machine_top_assert.svh -----
// Assertion macros for the stack calculator checker
`ifndef STACK_CALCULATOR_MACHINE_TOP_ASSERT_SVH
`define STACK_CALCULATOR_MACHINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/scm_pkg.sv -----
// Shared constants, codes and control types of the stack calculator
`default_nettype none

package scm_pkg;

  // Field and datapath widths
  localparam int VAL_W           = 31;
  localparam int LIM_W           = 30;
  localparam int FUNC_W          = 4;
  localparam int RES_W           = 2 * VAL_W;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int DIV_STEPS       = VAL_W;

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(1000000000);

  // Register index, taken from paddr[2]
  localparam logic REG_LIMIT = 1'b0;

  // Instruction codes
  localparam logic [FUNC_W-1:0] FUNC_START = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_NUM   = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_INV   = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_DUP   = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_SWP   = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_SUB   = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_MUL   = 4'd8;
  localparam logic [FUNC_W-1:0] FUNC_DIV   = 4'd9;
  localparam logic [FUNC_W-1:0] FUNC_MOD   = 4'd10;
  localparam logic [FUNC_W-1:0] FUNC_END   = 4'd11;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;      // capture operand of accepted word
    logic              start;     // reset stack to the operand alone
    logic              push_opnd; // push operand
    logic              push_tos;  // push copy of top
    logic              pop;       // drop top
    logic              inv;       // negate top
    logic              swap;      // exchange top two
    logic              arith;     // register add/sub/mul result
    logic              div_go;    // launch divider
    logic              commit;    // replace top two with result
    logic              emit;      // load output word
    logic              emit_err;  // error bit of output word
    logic [FUNC_W-1:0] func;      // current instruction
  } scm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic one;
    logic lt2;
    logic full;
    logic tos_zero;
    logic ovf;
    logic div_done;
    logic out_free;
  } scm_stat_t;

endpackage

`default_nettype wire

// ----- src/scm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, signed fixup
`default_nettype none

module scm_div import scm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quotient,
  output logic [VAL_W-1:0] remainder
);

  localparam int CW = $clog2(DIV_STEPS);
  localparam logic [CW-1:0] LAST = CW'(DIV_STEPS - 1);

  logic             busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [VAL_W-1:0] quo_r, rem_r, den_r;
  logic             negq_r, negr_r;

  logic [VAL_W-1:0] a_mag, b_mag;
  logic [VAL_W:0]   shl, diff;
  logic             ge;

  // Magnitudes of the signed operands
  assign a_mag = dividend[VAL_W-1] ? (~dividend + 1'b1) : dividend;
  assign b_mag = divisor[VAL_W-1]  ? (~divisor + 1'b1)  : divisor;

  // One restoring step
  assign shl  = {rem_r, quo_r[VAL_W-1]};
  assign diff = shl - {1'b0, den_r};
  assign ge   = ~diff[VAL_W];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= a_mag;
      rem_r  <= '0;
      den_r  <= b_mag;
      negq_r <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
      negr_r <= dividend[VAL_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[VAL_W-1:0] : shl[VAL_W-1:0];
      quo_r <= {quo_r[VAL_W-2:0], ge};
    end
  end

  // Truncating signs: quotient by sign mismatch, remainder follows dividend
  assign done      = done_r;
  assign quotient  = negq_r ? (~quo_r + 1'b1) : quo_r;
  assign remainder = negr_r ? (~rem_r + 1'b1) : rem_r;

endmodule

`default_nettype wire

// ----- src/scm_dp.sv -----
// Datapath: cached top two entries, stack memory, ALU, divider, output word
`default_nettype none

module scm_dp import scm_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [VAL_W-1:0] in_operand,
  input  scm_cmd_t         cmd,
  input  logic [LIM_W-1:0] limit,
  output scm_stat_t        stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_value,
  output logic             out_error
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);

  // Entries below the top two live in memory at their own index
  logic [VAL_W-1:0] mem [STACK_DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] tos_r, tos_nxt, nos_r, nos_nxt;
  logic [VAL_W-1:0] opnd_r, rd_r;
  logic signed [RES_W-1:0] res_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_valid_r, out_error_r;

  logic [CNT_W-1:0] cnt_m2, cnt_m3;
  logic             push, mem_we;
  logic [VAL_W-1:0] push_val, result;
  logic signed [RES_W-1:0] a_ext, b_ext, prod, arith_res;
  logic [RES_W-1:0] mag;
  logic             div_done;
  logic [VAL_W-1:0] div_q, div_r;

  assign cnt_m2   = count_r - CNT_TWO;
  assign cnt_m3   = count_r - CNT_THREE;
  assign push     = cmd.push_opnd | cmd.push_tos;
  assign push_val = cmd.push_opnd ? opnd_r : tos_r;
  assign mem_we   = push && (count_r >= CNT_TWO);

  // Operand capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r <= in_operand;
    end
  end

  // Stack memory: spill on push, entry under second refreshed every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m2[ADDR_W-1:0]] <= nos_r;
    end
    rd_r <= mem[cnt_m3[ADDR_W-1:0]];
  end

  // Add, subtract, multiply into a wide result register
  assign a_ext = RES_W'($signed(nos_r));
  assign b_ext = RES_W'($signed(tos_r));
  assign prod  = $signed(nos_r) * $signed(tos_r);

  always_comb begin
    case (cmd.func)
      FUNC_ADD: arith_res = a_ext + b_ext;
      FUNC_SUB: arith_res = a_ext - b_ext;
      default:  arith_res = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.arith) begin
      res_r <= arith_res;
    end
  end

  // Magnitude check against the limit
  assign mag = res_r[RES_W-1] ? (~res_r + 1'b1) : res_r;

  scm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_go),
    .dividend  (nos_r),
    .divisor   (tos_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Binary op result select
  always_comb begin
    case (cmd.func)
      FUNC_DIV: result = div_q;
      FUNC_MOD: result = div_r;
      default:  result = res_r[VAL_W-1:0];
    endcase
  end

  // Top two and count
  always_comb begin
    count_nxt = count_r;
    tos_nxt   = tos_r;
    nos_nxt   = nos_r;
    if (cmd.start) begin
      count_nxt = CNT_ONE;
      tos_nxt   = opnd_r;
    end else if (push) begin
      count_nxt = count_r + 1'b1;
      tos_nxt   = push_val;
      nos_nxt   = tos_r;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
      tos_nxt   = nos_r;
      nos_nxt   = rd_r;
    end else if (cmd.inv) begin
      tos_nxt = ~tos_r + 1'b1;
    end else if (cmd.swap) begin
      tos_nxt = nos_r;
      nos_nxt = tos_r;
    end else if (cmd.commit) begin
      count_nxt = count_r - 1'b1;
      tos_nxt   = result;
      nos_nxt   = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    nos_r <= nos_nxt;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= cmd.emit_err ? '0 : tos_r;
      out_error_r <= cmd.emit_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  // Status
  assign stat.empty    = (count_r == '0);
  assign stat.one      = (count_r == CNT_ONE);
  assign stat.lt2      = (count_r < CNT_TWO);
  assign stat.full     = (count_r == CNT_FULL);
  assign stat.tos_zero = (tos_r == '0);
  assign stat.ovf      = (mag > RES_W'(limit));
  assign stat.div_done = div_done;
  assign stat.out_free = ~out_valid_r | ~out_stall;

endmodule

`default_nettype wire

// ----- src/scm_ctrl.sv -----
// Controller: instruction decode, error flag and sequencing
`default_nettype none

module scm_ctrl import scm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  scm_stat_t         stat,
  output scm_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              err_r, err_nxt;
  logic [FUNC_W-1:0] func_r;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid & ~in_stall;

  // Instruction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
    end
  end

  // Next state, error flag and commands
  always_comb begin
    state_nxt    = state_r;
    err_nxt      = err_r;
    cmd          = '0;
    cmd.func     = func_r;
    cmd.load     = accept;
    cmd.emit_err = err_r | ~stat.one;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (func_r == FUNC_START) begin
          cmd.start = 1'b1;
          err_nxt   = 1'b0;
        end else if (func_r == FUNC_END) begin
          state_nxt = S_EMIT;
        end else if (!err_r && func_r < FUNC_END) begin
          unique case (func_r) inside
            FUNC_NUM: begin
              if (stat.full) err_nxt = 1'b1;
              else cmd.push_opnd = 1'b1;
            end
            FUNC_POP: begin
              if (stat.empty) err_nxt = 1'b1;
              else cmd.pop = 1'b1;
            end
            FUNC_INV: begin
              if (stat.empty) err_nxt = 1'b1;
              else cmd.inv = 1'b1;
            end
            FUNC_DUP: begin
              if (stat.empty || stat.full) err_nxt = 1'b1;
              else cmd.push_tos = 1'b1;
            end
            FUNC_SWP: begin
              if (stat.lt2) err_nxt = 1'b1;
              else cmd.swap = 1'b1;
            end
            FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
              if (stat.lt2) begin
                err_nxt = 1'b1;
              end else begin
                cmd.arith = 1'b1;
                state_nxt = S_CHK;
              end
            end
            FUNC_DIV, FUNC_MOD: begin
              if (stat.lt2 || stat.tos_zero) begin
                err_nxt = 1'b1;
              end else begin
                cmd.div_go = 1'b1;
                state_nxt  = S_DIV;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CHK: begin
        state_nxt = S_IDLE;
        if (stat.ovf) err_nxt = 1'b1;
        else cmd.commit = 1'b1;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/stack_calculator_machine_top.sv -----
// Stack calculator: one instruction word in, one result word per end instruction
//
// Input channel (in_valid/in_stall, in_func, in_operand): one instruction per
// word. A word is taken when in_valid is high and in_stall is low; in_stall is
// high while an instruction is in execution, so one instruction runs at a time.
// Each instruction is accepted in S_IDLE and executed in S_EXEC. start, num, pop,
//   inv, dup, swp, unused codes and anything but end while in error finish there;
//   add, sub, mul go on to S_CHK (multiply is registered before the limit compare);
//   div, mod wait in S_DIV for the 31-step restoring divider;
//   end waits in S_EMIT while the output register is still held by out_stall.
// Result channel (out_valid/out_stall, out_value, out_error): one word per end,
// held in an output register; new instructions are still taken while it waits.
// The top two stack entries sit in registers, the rest in a one-write,
// one-read memory of STACK_DEPTH entries with a registered read.
// Reset empties the stack, clears the error flag and the output valid flag and
// sets magnitude_limit to 1000000000. The APB port holds magnitude_limit at
// byte address 0; pready is always high.
`default_nettype none

module stack_calculator_machine_top import scm_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [VAL_W-1:0]  in_operand,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_error,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [LIM_W-1:0] limit_r;
  scm_cmd_t         cmd;
  scm_stat_t        stat;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
      limit_r <= pwdata[LIM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? CFG_DW'(limit_r) : '0;

  scm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd)
  );

  scm_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_operand (in_operand),
    .cmd        (cmd),
    .limit      (limit_r),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_error  (out_error)
  );

endmodule

`default_nettype wire

// ----- src/scm_chk.sv -----
// Port-level checker for the stack calculator, bound to the top level
`default_nettype none

`include "stack_calculator_machine_top_assert.svh"

module scm_chk import scm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_stall,
  input logic [VAL_W-1:0]  out_value,
  input logic              out_error
);

  // An error word carries a zero value
  `SCM_ASSERT_NOW(a_err_zero, out_valid && out_error, out_value == '0, "error word with nonzero value")

  // One instruction at a time: busy right after a word is taken
  `SCM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken back to back")

  // Only an end instruction produces a word
  `SCM_ASSERT_NEXT(a_no_spurious_out, in_valid && !in_stall && in_func != FUNC_END && !out_valid, !out_valid, "result without end")

  // A stalled result word holds
  `SCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_error), "stalled result changed")

endmodule

bind stack_calculator_machine_top scm_chk u_chk (.*);

`default_nettype wire
